// File: rtl/core/hbdt_pkg.sv
// ----------------------------------------------------------------------------
// H-bridge direction control package
// Shared word types, codes and fixed constants for the H-bridge block.
// ----------------------------------------------------------------------------
`default_nettype none

package hbdt_pkg;

  // Number of wheel slots that the 2-bit wheel field can address.
  localparam int unsigned MAX_WHEELS = 4;

  localparam int unsigned DUTY_W   = 16;
  localparam int unsigned LIMIT_W  = 11;
  localparam int unsigned PERIOD_W = 16;
  localparam int unsigned TICK_W   = 8;
  localparam int unsigned CFG_W    = 16;

  // Duty in 1/16 percent: full scale and the turn-off threshold (5 percent).
  localparam logic signed [DUTY_W:0] FULL_DUTY = 17'sd1600;
  localparam logic signed [DUTY_W:0] MIN_DUTY  = 17'sd80;

  // Division by 1600 is a shift by 6 and then a division by 25 done as a
  // multiply by a rounded-up reciprocal. With a 21-bit dividend the
  // reciprocal 2^26/25 rounded up gives the exact floor quotient.
  localparam int unsigned PROD_W     = PERIOD_W + LIMIT_W;
  localparam int unsigned DIV_SHIFT  = 6;
  localparam int unsigned DIVIDEND_W = PROD_W - DIV_SHIFT;
  localparam int unsigned RECIP_W    = 22;
  localparam int unsigned RECIP_SH   = 26;
  localparam int unsigned QUOT_W     = 17;
  localparam logic [RECIP_W-1:0] DIV25_RECIP = 22'd2684355;

  // Function codes of an input word.
  localparam logic FUNC_TICK = 1'b0;
  localparam logic FUNC_CMD  = 1'b1;

  // Configuration register indexes.
  localparam logic CFG_DUTY_LIMIT = 1'b0;
  localparam logic CFG_CNT_PERIOD = 1'b1;

  typedef enum logic [1:0] {
    MODE_REVERSE = 2'd0,
    MODE_BRAKE   = 2'd1,
    MODE_FORWARD = 2'd2
  } mode_e;

  typedef struct packed {
    logic                     func;
    logic [1:0]               wheel;
    logic signed [DUTY_W-1:0] duty_cmd;
  } in_word_t;

  typedef struct packed {
    logic [1:0]          wheel_out;
    logic                drive_cw;
    logic                drive_ccw;
    logic [PERIOD_W-1:0] compare_value;
  } out_word_t;

  // Decision of the wheel controller handed to the scaling pipeline.
  typedef struct packed {
    logic [1:0]         wheel;
    logic               cw;
    logic               ccw;
    logic [LIMIT_W-1:0] duty;
  } drive_t;

endpackage

`default_nettype wire

// File: rtl/core/hbdt_wheel_ctrl.sv
// ----------------------------------------------------------------------------
// Wheel controller
// Per-wheel mode, previous duty and dead-time counters, updated on accept.
// ----------------------------------------------------------------------------
`default_nettype none

module hbdt_wheel_ctrl #(
  parameter int unsigned DEAD_TICKS = 10,
  parameter int unsigned NUM_WHEELS = 4
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         accept_i,
  input  wire hbdt_pkg::in_word_t           in_data_i,
  input  wire logic [hbdt_pkg::LIMIT_W-1:0] duty_limit_i,
  output hbdt_pkg::drive_t                  drive_o,
  output logic                              drive_valid_o
);
  import hbdt_pkg::*;

  localparam int unsigned NumSlots = (NUM_WHEELS < MAX_WHEELS) ? NUM_WHEELS : MAX_WHEELS;
  localparam logic [TICK_W-1:0] DeadTicks = TICK_W'(DEAD_TICKS);

  mode_e                    mode_q [NumSlots];
  mode_e                    mode_d [NumSlots];
  logic signed [DUTY_W-1:0] prev_q [NumSlots];
  logic signed [DUTY_W-1:0] prev_d [NumSlots];
  logic [TICK_W-1:0]        tick_q [NumSlots];
  logic [TICK_W-1:0]        tick_d [NumSlots];

  logic                     hit;
  mode_e                    mode_r;
  logic signed [DUTY_W-1:0] prev_r;
  logic [TICK_W-1:0]        tick_r;

  logic signed [DUTY_W:0]   duty_x;
  logic signed [DUTY_W:0]   prev_x;
  logic signed [DUTY_W:0]   diff;
  logic signed [DUTY_W:0]   abs_diff;
  logic signed [DUTY_W:0]   sum;
  logic                     same_sign;
  logic signed [DUTY_W-1:0] duty1;
  mode_e                    target;
  logic                     mode_match;
  logic signed [DUTY_W:0]   duty2;
  logic                     cw_raw;
  logic                     ccw_raw;
  logic                     above_min;
  logic [LIMIT_W-1:0]       duty_c;
  logic signed [DUTY_W-1:0] duty_store;

  // Select the addressed wheel's state.
  always_comb begin
    hit    = 1'b0;
    mode_r = MODE_REVERSE;
    prev_r = '0;
    tick_r = '0;
    for (int k = 0; k < NumSlots; k++) begin
      if (in_data_i.wheel == 2'(k)) begin
        hit    = 1'b1;
        mode_r = mode_q[k];
        prev_r = prev_q[k];
        tick_r = tick_q[k];
      end
    end
  end

  // Averaging of a large same-sign step, target mode and bridge sides.
  always_comb begin
    duty_x    = {in_data_i.duty_cmd[DUTY_W-1], in_data_i.duty_cmd};
    prev_x    = {prev_r[DUTY_W-1], prev_r};
    diff      = duty_x - prev_x;
    abs_diff  = diff[DUTY_W] ? -diff : diff;
    sum       = duty_x + prev_x;
    same_sign = (duty_x > 0 && prev_x > 0) || (duty_x < 0 && prev_x < 0);
    duty1     = (same_sign && abs_diff >= FULL_DUTY) ? sum[DUTY_W:1] : in_data_i.duty_cmd;

    if (duty1 < 0) begin
      target = MODE_REVERSE;
    end else if (duty1 == 0) begin
      target = MODE_BRAKE;
    end else begin
      target = MODE_FORWARD;
    end
    mode_match = (mode_r == target);

    duty2   = {duty1[DUTY_W-1], duty1};
    cw_raw  = 1'b0;
    ccw_raw = 1'b0;
    if (mode_match) begin
      case (target)
        MODE_REVERSE: begin
          duty2   = -{duty1[DUTY_W-1], duty1};
          ccw_raw = 1'b1;
        end
        MODE_BRAKE: begin
          duty2   = FULL_DUTY;
          cw_raw  = 1'b1;
          ccw_raw = 1'b1;
        end
        MODE_FORWARD: begin
          cw_raw = 1'b1;
        end
        default: begin
          cw_raw = 1'b0;
        end
      endcase
    end

    // Above the threshold the duty is positive, so its magnitude bits
    // compare directly against the limit.
    above_min = (duty2 > MIN_DUTY);
    if (!above_min) begin
      duty_c     = '0;
      duty_store = duty2[DUTY_W-1:0];
    end else if (duty2[DUTY_W-1:0] > DUTY_W'(duty_limit_i)) begin
      duty_c     = duty_limit_i;
      duty_store = DUTY_W'(duty_limit_i);
    end else begin
      duty_c     = duty2[LIMIT_W-1:0];
      duty_store = duty2[DUTY_W-1:0];
    end
  end

  // Next state of all wheels.
  always_comb begin
    mode_d = mode_q;
    prev_d = prev_q;
    tick_d = tick_q;
    if (accept_i) begin
      if (in_data_i.func == FUNC_TICK) begin
        for (int k = 0; k < NumSlots; k++) begin
          if (tick_q[k] != '1) begin
            tick_d[k] = tick_q[k] + 1'b1;
          end
        end
      end else begin
        for (int k = 0; k < NumSlots; k++) begin
          if (in_data_i.wheel == 2'(k)) begin
            prev_d[k] = duty_store;
            if (mode_match) begin
              tick_d[k] = '0;
            end else if (tick_r >= DeadTicks) begin
              mode_d[k] = target;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NumSlots; k++) begin
        mode_q[k] <= MODE_REVERSE;
        prev_q[k] <= '0;
        tick_q[k] <= '0;
      end
    end else begin
      mode_q <= mode_d;
      prev_q <= prev_d;
      tick_q <= tick_d;
    end
  end

  assign drive_valid_o = accept_i && (in_data_i.func == FUNC_CMD) && hit;
  assign drive_o.wheel = in_data_i.wheel;
  assign drive_o.cw    = cw_raw && above_min;
  assign drive_o.ccw   = ccw_raw && above_min;
  assign drive_o.duty  = duty_c;

endmodule

`default_nettype wire

// File: rtl/core/hbdt_scale.sv
// ----------------------------------------------------------------------------
// Compare scaling pipeline
// Two registered stages: period times duty, then division by 1600.
// ----------------------------------------------------------------------------
`default_nettype none

module hbdt_scale (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          drive_valid_i,
  input  wire hbdt_pkg::drive_t              drive_i,
  output logic                               ready_o,
  input  wire logic [hbdt_pkg::PERIOD_W-1:0] cnt_period_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output hbdt_pkg::out_word_t                out_data_o
);
  import hbdt_pkg::*;

  typedef struct packed {
    logic [1:0]        wheel;
    logic              cw;
    logic              ccw;
    logic [PROD_W-1:0] product;
  } stage_t;

  logic      s1_valid_q;
  stage_t    s1_q;
  logic      out_valid_q;
  out_word_t out_q;

  logic                           out_take;
  logic                           s1_take;
  logic [DIVIDEND_W-1:0]          dividend;
  logic [DIVIDEND_W+RECIP_W-1:0]  recip_prod;
  logic [QUOT_W-1:0]              quot;
  logic [PERIOD_W-1:0]            cmp;

  assign out_take = !out_valid_q || out_ready_i;
  assign s1_take  = !s1_valid_q || out_take;
  assign ready_o  = s1_take;

  assign dividend   = s1_q.product[PROD_W-1:DIV_SHIFT];
  assign recip_prod = {{RECIP_W{1'b0}}, dividend} * {{DIVIDEND_W{1'b0}}, DIV25_RECIP};
  assign quot       = recip_prod[RECIP_SH +: QUOT_W];
  assign cmp        = quot[QUOT_W-1] ? '1 : quot[PERIOD_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_take) begin
        s1_valid_q <= drive_valid_i;
      end
      if (out_take) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_take && drive_valid_i) begin
      s1_q.wheel   <= drive_i.wheel;
      s1_q.cw      <= drive_i.cw;
      s1_q.ccw     <= drive_i.ccw;
      s1_q.product <= {{LIMIT_W{1'b0}}, cnt_period_i} * {{PERIOD_W{1'b0}}, drive_i.duty};
    end
    if (out_take && s1_valid_q) begin
      out_q.wheel_out     <= s1_q.wheel;
      out_q.drive_cw      <= s1_q.cw;
      out_q.drive_ccw     <= s1_q.ccw;
      out_q.compare_value <= cmp;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

// File: rtl/core/h_bridge_direction_dead_time.sv
// ----------------------------------------------------------------------------
// H-bridge direction control with dead time
// Drives the bridge sides and PWM compare value of up to four wheels.
// ----------------------------------------------------------------------------
//
//   Channel   Signals                          Direction  Word
//   in        in_valid_i/in_ready_o/in_data_i  input      tick or duty command
//   out       out_valid_o/out_ready_i/out_data_o output   bridge sides, compare
//   cfg       cfg_we_i/cfg_addr_i/cfg_wdata_i  input      register write
//
// One input word is accepted per cycle while the pipeline can take it. The
// wheel state (mode, previous duty and dead-time counter) is read and updated
// in the cycle of acceptance, so a word for the same wheel may follow directly.
// For a command's result word, one stage forms the period-times-duty product,
// the next divides it by 1600 with a reciprocal multiply into the output
// register. Reset puts every wheel in reverse mode with zero duty and zero
// ticks, and the registers at a 1600 duty limit and a 1000 count period. A
// stalled output holds its word; the input keeps being taken while a
// pipeline stage is free. Ticks and commands for absent wheels give no word.
//
`default_nettype none

module h_bridge_direction_dead_time #(
  parameter int unsigned DEAD_TICKS = 10,
  parameter int unsigned NUM_WHEELS = 4
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_ready_o,
  input  wire hbdt_pkg::in_word_t         in_data_i,
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output hbdt_pkg::out_word_t             out_data_o,
  input  wire logic                       cfg_we_i,
  input  wire logic                       cfg_addr_i,
  input  wire logic [hbdt_pkg::CFG_W-1:0] cfg_wdata_i
);
  import hbdt_pkg::*;

  logic [LIMIT_W-1:0]  duty_limit_q;
  logic [PERIOD_W-1:0] cnt_period_q;

  logic   accept;
  drive_t drive;
  logic   drive_valid;

  // Configuration registers; user writes only while block idle; not enforced.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      duty_limit_q <= 11'd1600;
      cnt_period_q <= 16'd1000;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        CFG_DUTY_LIMIT: duty_limit_q <= cfg_wdata_i[LIMIT_W-1:0];
        CFG_CNT_PERIOD: cnt_period_q <= cfg_wdata_i[PERIOD_W-1:0];
        default:        duty_limit_q <= duty_limit_q;
      endcase
    end
  end

  assign accept = in_valid_i && in_ready_o;

  // Per-wheel decision: averaging, target mode, dead time and clamping.
  hbdt_wheel_ctrl #(
    .DEAD_TICKS (DEAD_TICKS),
    .NUM_WHEELS (NUM_WHEELS)
  ) u_wheel_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .in_data_i     (in_data_i),
    .duty_limit_i  (duty_limit_q),
    .drive_o       (drive),
    .drive_valid_o (drive_valid)
  );

  // Compare value pipeline and output register.
  hbdt_scale u_scale (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .drive_valid_i (drive_valid),
    .drive_i       (drive),
    .ready_o       (in_ready_o),
    .cnt_period_i  (cnt_period_q),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_data_o    (out_data_o)
  );

endmodule

`default_nettype wire

// File: tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// H-bridge direction control testbench
// Drives tick and duty command words into the block, predicts each bridge word
// from a behavioral copy of the wheel state, and checks every output word.
// ----------------------------------------------------------------------------

module tb_top;

  import hbdt_pkg::*;

  localparam int unsigned DEAD_TICKS  = 10;
  localparam int unsigned N_WHEELS    = 4;
  // Padding waited out after the last due word has left the block, a good
  // margin before touching the registers.
  localparam int unsigned LAT_PAD     = 8;
  // Longest correct quiet stretch is a sender gap plus a receiver stall plus
  // the pipeline and a register write, far below this limit.
  localparam int unsigned QUIET_LIMIT = 1000;
  localparam int unsigned BATCH_WORDS = 100;

  // One row of the directed table. When has_exp is set the expected word is
  // typed in; otherwise the predictor decides.
  typedef struct packed {
    in_word_t  word;
    logic      has_exp;
    out_word_t exp;
  } dir_row_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  in_word_t           in_data = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  out_word_t          out_data;
  logic               cfg_we = 1'b0;
  logic               cfg_addr = CFG_DUTY_LIMIT;
  logic [CFG_W-1:0]   cfg_wdata = '0;

  // Typed expectation that travels along with the word on the input channel.
  // It is registered with the word so that the acceptance monitor samples it
  // at the same edge as the word itself.
  logic               row_has_exp = 1'b0;
  out_word_t          row_exp = '0;

  // Shadow copy of the block's state and registers, reset values included.
  mode_e              bridge_mode [N_WHEELS] = '{default: MODE_REVERSE};
  int                 last_duty [N_WHEELS] = '{default: 0};
  logic [TICK_W-1:0]  dead_ticks [N_WHEELS] = '{default: '0};
  logic [LIMIT_W-1:0] duty_limit = 11'd1600;
  logic [PERIOD_W-1:0] cnt_period = 16'd1000;

  out_word_t          bridge_words_due [$];
  int unsigned        mismatches = 0;
  int unsigned        quiet_cycles = 0;
  bit                 idle_en = 1'b1;

  h_bridge_direction_dead_time #(
    .DEAD_TICKS(DEAD_TICKS),
    .NUM_WHEELS(N_WHEELS)
  ) uut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data),
    .cfg_we_i   (cfg_we),
    .cfg_addr_i (cfg_addr),
    .cfg_wdata_i(cfg_wdata)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Directed table. After reset every wheel is in reverse mode with zero
  // duty and zero ticks, the limit is 1600 and the period is 1000.
  dir_row_t dir_rows [23] = '{
    // Full reverse matches the reset mode: counter-clockwise at full scale.
    '{'{FUNC_CMD, 2'd0, -16'sd1600}, 1'b1, '{2'd0, 1'b0, 1'b1, 16'd1000}},
    // Brake request while in reverse with no ticks: dead time, all off.
    '{'{FUNC_CMD, 2'd1, 16'sd0}, 1'b1, '{2'd1, 1'b0, 1'b0, 16'd0}},
    // Largest forward duty in dead time: sides off, compare still scaled.
    '{'{FUNC_CMD, 2'd2, 16'sh7FFF}, 1'b1, '{2'd2, 1'b0, 1'b0, 16'd1000}},
    // Most negative duty in reverse: negated, then clamped to the limit.
    '{'{FUNC_CMD, 2'd3, 16'sh8000}, 1'b1, '{2'd3, 1'b0, 1'b1, 16'd1000}},
    // Exactly 5 percent in reverse is still too small: all off.
    '{'{FUNC_CMD, 2'd0, -16'sd80}, 1'b1, '{2'd0, 1'b0, 1'b0, 16'd0}},
    // Just above 5 percent in reverse.
    '{'{FUNC_CMD, 2'd0, -16'sd81}, 1'b0, '0},
    // Ten ticks open the dead time on every wheel. Their other fields are
    // don't-care and are varied to exercise the bits.
    '{'{FUNC_TICK, 2'd3, 16'sh7FFF}, 1'b0, '0},
    '{'{FUNC_TICK, 2'd0, 16'sh8000}, 1'b0, '0},
    '{'{FUNC_TICK, 2'd1, 16'shFFFF}, 1'b0, '0},
    '{'{FUNC_TICK, 2'd2, 16'sh0000}, 1'b0, '0},
    '{'{FUNC_TICK, 2'd3, 16'sh5555}, 1'b0, '0},
    '{'{FUNC_TICK, 2'd0, 16'shAAAA}, 1'b0, '0},
    '{'{FUNC_TICK, 2'd1, 16'sh0F0F}, 1'b0, '0},
    '{'{FUNC_TICK, 2'd2, 16'shF0F0}, 1'b0, '0},
    '{'{FUNC_TICK, 2'd3, 16'sh00FF}, 1'b0, '0},
    '{'{FUNC_TICK, 2'd0, 16'shFF00}, 1'b0, '0},
    // Dead time over: the mode turns to brake, this word is still off.
    '{'{FUNC_CMD, 2'd1, 16'sd0}, 1'b1, '{2'd1, 1'b0, 1'b0, 16'd0}},
    // Brake now matches: both sides on at full scale.
    '{'{FUNC_CMD, 2'd1, 16'sd0}, 1'b1, '{2'd1, 1'b1, 1'b1, 16'd1000}},
    // Mode change to forward on the wheel that waited out its dead time.
    '{'{FUNC_CMD, 2'd2, 16'sd100}, 1'b0, '0},
    // Same sign and a jump of at least full scale: averaged with the old duty.
    '{'{FUNC_CMD, 2'd2, 16'sh7FFF}, 1'b0, '0},
    // Tiny reverse duty, off, stored as a positive magnitude.
    '{'{FUNC_CMD, 2'd3, -16'sd1}, 1'b0, '0},
    // Reverse request while braking with the counter cleared: a negative
    // duty is stored as is during dead time...
    '{'{FUNC_CMD, 2'd1, -16'sd5000}, 1'b0, '0},
    // ...so the next negative command is averaged with a negative history.
    '{'{FUNC_CMD, 2'd1, 16'sh8000}, 1'b0, '0}
  };

  // Prints one line for a mismatch and counts it.
  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("[%0t] mismatch in %s: got %0d, expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  // Behavioral model of one accepted word. Updates the shadow state and
  // returns 1 when the word produces a bridge word.
  function automatic bit predict_bridge_word(input in_word_t w, output out_word_t r);
    int     wi;
    int     duty;
    int     prev;
    int     diff;
    longint prod;
    mode_e  tgt;
    logic   cw;
    logic   ccw;
    logic [PERIOD_W-1:0] cmp;

    r = '0;
    if (w.func == FUNC_TICK) begin
      for (int k = 0; k < N_WHEELS; k++) begin
        if (dead_ticks[k] != '1) begin
          dead_ticks[k] = dead_ticks[k] + 1'b1;
        end
      end
      return 1'b0;
    end
    wi = int'(w.wheel);
    if (wi >= N_WHEELS) begin
      return 1'b0;
    end

    duty = int'(w.duty_cmd);
    prev = last_duty[wi];
    // Large jump in the same direction: take the floor of the average.
    if ((duty > 0 && prev > 0) || (duty < 0 && prev < 0)) begin
      diff = duty - prev;
      if (diff < 0) begin
        diff = -diff;
      end
      if (diff >= int'(FULL_DUTY)) begin
        duty = (duty + prev) >>> 1;
      end
    end

    tgt = (duty < 0) ? MODE_REVERSE : ((duty == 0) ? MODE_BRAKE : MODE_FORWARD);
    cw  = 1'b0;
    ccw = 1'b0;
    if (bridge_mode[wi] != tgt) begin
      // Bridge stays off; the mode follows only after the dead time.
      if (dead_ticks[wi] >= DEAD_TICKS) begin
        bridge_mode[wi] = tgt;
      end
    end else begin
      dead_ticks[wi] = '0;
      case (tgt)
        MODE_REVERSE: begin
          duty = -duty;
          ccw  = 1'b1;
        end
        MODE_BRAKE: begin
          cw   = 1'b1;
          ccw  = 1'b1;
          duty = int'(FULL_DUTY);
        end
        default: begin
          cw = 1'b1;
        end
      endcase
    end

    if (duty > int'(MIN_DUTY)) begin
      if (duty > int'(duty_limit)) begin
        duty = int'(duty_limit);
      end
      prod = longint'(cnt_period) * duty / int'(FULL_DUTY);
      cmp  = (prod > 65535) ? '1 : prod[PERIOD_W-1:0];
    end else begin
      cw  = 1'b0;
      ccw = 1'b0;
      cmp = '0;
    end

    last_duty[wi] = duty;
    r = '{w.wheel, cw, ccw, cmp};
    return 1'b1;
  endfunction

  // Register writes and accepted input words feed the model at the same
  // edge at which the block sees them.
  always @(posedge clk) begin : track_inputs
    out_word_t pred;
    if (rst_n) begin
      if (cfg_we) begin
        case (cfg_addr)
          CFG_DUTY_LIMIT: duty_limit = cfg_wdata[LIMIT_W-1:0];
          CFG_CNT_PERIOD: cnt_period = cfg_wdata[PERIOD_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        if (predict_bridge_word(in_data, pred)) begin
          bridge_words_due.push_back(row_has_exp ? row_exp : pred);
        end
      end
    end
  end

  // Every output word is compared with the oldest word still due.
  always @(posedge clk) begin : check_outputs
    out_word_t want;
    if (rst_n && out_valid && out_ready) begin
      if (bridge_words_due.size() == 0) begin
        report_mismatch("word with nothing due", out_data, 0);
      end else begin
        want = bridge_words_due.pop_front();
        if (out_data.wheel_out !== want.wheel_out) begin
          report_mismatch("wheel_out", out_data.wheel_out, want.wheel_out);
        end
        if (out_data.drive_cw !== want.drive_cw) begin
          report_mismatch("drive_cw", out_data.drive_cw, want.drive_cw);
        end
        if (out_data.drive_ccw !== want.drive_ccw) begin
          report_mismatch("drive_ccw", out_data.drive_ccw, want.drive_ccw);
        end
        if (out_data.compare_value !== want.compare_value) begin
          report_mismatch("compare_value", out_data.compare_value, want.compare_value);
        end
      end
    end
  end

  // Watchdog: too many cycles without any word moving ends the run.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Output side: random stall bursts between ready stretches, and always
  // ready once idling is switched off.
  initial begin
    @(posedge clk);
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (idle_en && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
  end

  // Offers one word, sometimes after an idle burst, and returns at the edge
  // that accepts it. Valid stays high across back-to-back words.
  task automatic push_word(input in_word_t w);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
  endtask

  // Waits until every expected word has left the block, then waits out the
  // LAT_PAD padding since ticks give no word to wait for.
  task automatic settle_bridge();
    @(posedge clk);
    while (bridge_words_due.size() != 0) @(posedge clk);
    repeat (LAT_PAD) @(posedge clk);
  endtask

  // Writes both registers on consecutive edges.
  task automatic write_limits(input logic [LIMIT_W-1:0] lim, input logic [PERIOD_W-1:0] per);
    cfg_we    <= 1'b1;
    cfg_addr  <= CFG_DUTY_LIMIT;
    cfg_wdata <= CFG_W'(lim);
    @(posedge clk);
    cfg_addr  <= CFG_CNT_PERIOD;
    cfg_wdata <= per;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Random words: mostly duty commands whose sign per wheel tends to persist,
  // so wheels settle into a mode, with occasional reversals and bursts of
  // ticks that let the dead time run out.
  task automatic run_batch(input int unsigned n_words);
    in_word_t    w;
    int unsigned sent;
    int unsigned burst;
    int          mag;
    bit          raw;
    bit          neg_pref [N_WHEELS];

    sent = 0;
    for (int k = 0; k < N_WHEELS; k++) begin
      neg_pref[k] = 1'($urandom);
    end
    while (sent < n_words) begin
      if ($urandom_range(0, 9) == 0) begin
        burst = $urandom_range(1, 12);
        repeat (burst) begin
          w.func     = FUNC_TICK;
          w.wheel    = 2'($urandom);
          w.duty_cmd = 16'($urandom);
          push_word(w);
        end
        sent += burst;
      end else begin
        w.func  = FUNC_CMD;
        w.wheel = 2'($urandom);
        if ($urandom_range(0, 4) == 0) begin
          neg_pref[w.wheel] = ~neg_pref[w.wheel];
        end
        raw = 1'b0;
        case ($urandom_range(0, 7))
          0: raw = 1'b1;
          1: mag = $urandom_range(0, 100);
          2: mag = $urandom_range(1500, 1700);
          3: mag = $urandom_range(1600, 4000);
          4: mag = 0;
          5: begin
            case ($urandom_range(0, 4))
              0: mag = 80;
              1: mag = 81;
              2: mag = 1600;
              3: mag = 32767;
              default: mag = 32768;
            endcase
          end
          default: mag = $urandom_range(81, 1600);
        endcase
        w.duty_cmd = raw ? 16'($urandom) : 16'(neg_pref[w.wheel] ? -mag : mag);
        push_word(w);
        sent++;
      end
    end
    in_valid <= 1'b0;
  endtask

  initial begin : main_seq
    in_word_t          w;
    logic [LIMIT_W-1:0] lim_val;
    logic [PERIOD_W-1:0] per_val;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part under the reset register values.
    for (int i = 0; i < $size(dir_rows); i++) begin
      row_exp     <= dir_rows[i].exp;
      row_has_exp <= dir_rows[i].has_exp;
      push_word(dir_rows[i].word);
    end
    in_valid    <= 1'b0;
    row_has_exp <= 1'b0;

    // Random part, one batch per register setting. The first three settings
    // hit compare saturation, a zero limit with the smallest period, and a
    // zero period; the last restores the reset values and runs without idling.
    for (int p = 0; p < 6; p++) begin
      case (p)
        0: begin
          lim_val = '1;
          per_val = '1;
        end
        1: begin
          lim_val = '0;
          per_val = 16'd1;
        end
        2: begin
          lim_val = 11'd1600;
          per_val = '0;
        end
        5: begin
          lim_val = 11'd1600;
          per_val = 16'd1000;
        end
        default: begin
          lim_val = 11'($urandom);
          per_val = 16'($urandom);
        end
      endcase
      settle_bridge();
      if (p == 5) begin
        idle_en = 1'b0;
      end
      write_limits(lim_val, per_val);
      if (p == 2) begin
        // A long run of ticks drives every counter into saturation.
        w.func     = FUNC_TICK;
        w.duty_cmd = '0;
        repeat (260) begin
          w.wheel = 2'($urandom);
          push_word(w);
        end
      end
      run_batch(BATCH_WORDS);
    end

    settle_bridge();
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
